// ===== hw/rtl/rvtc_pkg.sv =====
// Shared types and constants of the rectangle versus tile map collision block.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package rvtc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_W  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_H  = 4'd3;

	localparam logic [CFG_DATA_W-1:0] RST_TILE_W = 9'd16;
	localparam logic [CFG_DATA_W-1:0] RST_TILE_H = 9'd16;
	localparam logic [CFG_DATA_W-1:0] RST_MAP_W  = 9'd256;
	localparam logic [CFG_DATA_W-1:0] RST_MAP_H  = 9'd256;

	// Input item layout
	localparam int TILE_IDX_W = 8;
	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 12;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 8;

	localparam int COL_LSB   = 0;
	localparam int ROW_LSB   = 8;
	localparam int SOLID_BIT = 16;
	localparam int LEFT_LSB  = 17;
	localparam int TOP_LSB   = 33;
	localparam int WIDTH_LSB = 49;
	localparam int HGT_LSB   = 61;

	// Divider: four lanes, one per span edge
	localparam int DIVD_W    = 16;
	localparam int DVSR_W    = 9;
	localparam int DIV_LANES = 4;
	localparam int DIV_CNT_W = $clog2(DIVD_W);
	localparam int LANE_LO_X = 0;
	localparam int LANE_HI_X = 1;
	localparam int LANE_LO_Y = 2;
	localparam int LANE_HI_Y = 3;

	// Span arithmetic width, holds any clamp limit and a quotient
	localparam int SPAN_W = 17;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic clear_en;
		logic wb_en;
		logic span_en;
		logic scan_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_is_query;
		logic clear_last;
		logic div_done;
		logic span_ok;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rvtc_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module rvtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rvtc_div.sv =====
// Four-lane restoring divider, one quotient bit per lane per cycle.
// Depends on rvtc_pkg for operand widths and lane count.
`default_nettype none

module rvtc_div
	import rvtc_pkg::*;
(
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [DIV_LANES-1:0][DIVD_W-1:0]    dividend,
	input  wire logic [DIV_LANES-1:0][DVSR_W-1:0]    divisor,
	output logic                                     done,
	output logic      [DIV_LANES-1:0][DIVD_W-1:0]    quotient
);
	logic [DIV_LANES-1:0][DIVD_W-1:0] num_q;
	logic [DIV_LANES-1:0][DVSR_W-1:0] rem_q;
	logic [DIV_LANES-1:0][DVSR_W-1:0] dvs_q;
	logic [DIV_LANES-1:0][DIVD_W-1:0] num_d;
	logic [DIV_LANES-1:0][DVSR_W-1:0] rem_d;
	logic [DIV_CNT_W-1:0]             cnt_q;
	logic                             busy_q;
	logic                             done_q;

	// One restoring step per lane: shift in the next dividend bit, subtract if it fits
	always_comb begin
		for (int i = 0; i < DIV_LANES; i++) begin
			logic [DVSR_W:0] rem_sh;
			logic [DVSR_W:0] diff;
			rem_sh = {rem_q[i], num_q[i][DIVD_W-1]};
			diff   = rem_sh - {1'b0, dvs_q[i]};
			if (rem_sh >= {1'b0, dvs_q[i]}) begin
				rem_d[i] = diff[DVSR_W-1:0];
				num_d[i] = {num_q[i][DIVD_W-2:0], 1'b1};
			end else begin
				rem_d[i] = rem_sh[DVSR_W-1:0];
				num_d[i] = {num_q[i][DIVD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rvtc_ctrl.sv =====
// Sequencer of the collision block: clear pass, tile writes and queries.
// Depends on rvtc_pkg for the command and status structs.
`default_nettype none

module rvtc_ctrl
	import rvtc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t status,
	output cmd_t         cmd
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WB    = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_SPAN  = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = status.in_is_query ? ST_DIV : ST_WB;
				end
			end
			ST_WB: begin
				cmd.wb_en = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.span_en = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!status.span_ok) begin
					state_d = ST_OUT;
				end else begin
					cmd.scan_en = 1'b1;
					if (status.scan_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide wait");

	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && status.out_free) |=> state_q == ST_IDLE)
		else $error("result load did not return to idle");

	a_scan_needs_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_en |-> (status.span_ok && $past(state_q) != ST_DIV))
		else $error("row scan without a valid tile span");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rvtc_dp.sv =====
// Datapath of the collision block: config registers, tile row store, span math,
// row scan and result register. Depends on rvtc_pkg, rvtc_div and rvtc_ram.
`default_nettype none

module rvtc_dp
	import rvtc_pkg::*;
#(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic                  in_op,
	input  wire logic                  out_ready,
	output status_t                    status,
	output logic                       out_valid,
	output logic      [OUT_DATA_W-1:0] out_data
);
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [SPAN_W-1:0] COLS_LIM = SPAN_W'(MAX_COLS);
	localparam logic [SPAN_W-1:0] ROWS_LIM = SPAN_W'(MAX_ROWS);

	// Configuration
	logic [CFG_DATA_W-1:0] tile_w_q, tile_h_q, map_w_q, map_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w_q <= RST_TILE_W;
			tile_h_q <= RST_TILE_H;
			map_w_q  <= RST_MAP_W;
			map_h_q  <= RST_MAP_H;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILE_W: tile_w_q <= cfg_data;
				REG_TILE_H: tile_h_q <= cfg_data;
				REG_MAP_W:  map_w_q  <= cfg_data;
				REG_MAP_H:  map_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input field decode
	logic [TILE_IDX_W-1:0] f_col, f_row;
	logic                  f_solid;
	logic [COORD_W-1:0]    f_left, f_top;
	logic [SIZE_W-1:0]     f_w, f_h;

	assign f_col   = in_data[COL_LSB +: TILE_IDX_W];
	assign f_row   = in_data[ROW_LSB +: TILE_IDX_W];
	assign f_solid = in_data[SOLID_BIT];
	assign f_left  = in_data[LEFT_LSB +: COORD_W];
	assign f_top   = in_data[TOP_LSB +: COORD_W];
	assign f_w     = in_data[WIDTH_LSB +: SIZE_W];
	assign f_h     = in_data[HGT_LSB +: SIZE_W];

	// Exclusive end edges, signed in 18 bits
	logic [COORD_W+1:0] end_x, end_y;
	logic [COORD_W-1:0] hi_x, hi_y, lo_x, lo_y;
	logic               ok_x, ok_y;

	assign end_x = {{2{f_left[COORD_W-1]}}, f_left} + {6'b0, f_w};
	assign end_y = {{2{f_top[COORD_W-1]}}, f_top} + {6'b0, f_h};
	assign hi_x  = end_x[COORD_W-1:0] - 1'b1;
	assign hi_y  = end_y[COORD_W-1:0] - 1'b1;
	assign lo_x  = f_left[COORD_W-1] ? '0 : f_left;
	assign lo_y  = f_top[COORD_W-1] ? '0 : f_top;
	assign ok_x  = (f_w != '0) && !end_x[COORD_W+1] && (end_x != '0);
	assign ok_y  = (f_h != '0) && !end_y[COORD_W+1] && (end_y != '0);

	// Divider
	logic [DIV_LANES-1:0][DIVD_W-1:0] div_num, div_quo;
	logic [DIV_LANES-1:0][DVSR_W-1:0] div_dvs;
	logic [DVSR_W-1:0]                dvs_x, dvs_y;
	logic                             div_done;

	assign dvs_x = (tile_w_q == '0) ? DVSR_W'(1) : tile_w_q;
	assign dvs_y = (tile_h_q == '0) ? DVSR_W'(1) : tile_h_q;

	assign div_num[LANE_LO_X] = lo_x;
	assign div_num[LANE_HI_X] = hi_x;
	assign div_num[LANE_LO_Y] = lo_y;
	assign div_num[LANE_HI_Y] = hi_y;
	assign div_dvs[LANE_LO_X] = dvs_x;
	assign div_dvs[LANE_HI_X] = dvs_x;
	assign div_dvs[LANE_LO_Y] = dvs_y;
	assign div_dvs[LANE_HI_Y] = dvs_y;

	rvtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept && in_op),
		.dividend (div_num),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Per-item registers
	logic             ok_x_q, ok_y_q;
	logic [ROW_W-1:0] wr_row_q;
	logic [COL_W-1:0] wr_col_q;
	logic             wr_bit_q, wr_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ok_x_q   <= ok_x;
			ok_y_q   <= ok_y;
			wr_row_q <= ROW_W'(f_row);
			wr_col_q <= COL_W'(f_col);
			wr_bit_q <= f_solid;
			wr_ok_q  <= (32'(f_col) < 32'(MAX_COLS)) && (32'(f_row) < 32'(MAX_ROWS));
		end
	end

	// Span: clamp the far edge to the map in use, reject empty ranges
	logic [SPAN_W-1:0] lim_c, lim_r, lim_c_m1, lim_r_m1;
	logic [SPAN_W-1:0] q_lo_x, q_hi_x, q_lo_y, q_hi_y, hic_x, hic_y;
	logic              span_ok;

	assign lim_c    = ({8'b0, map_w_q} < COLS_LIM) ? {8'b0, map_w_q} : COLS_LIM;
	assign lim_r    = ({8'b0, map_h_q} < ROWS_LIM) ? {8'b0, map_h_q} : ROWS_LIM;
	assign lim_c_m1 = lim_c - 1'b1;
	assign lim_r_m1 = lim_r - 1'b1;
	assign q_lo_x   = {1'b0, div_quo[LANE_LO_X]};
	assign q_hi_x   = {1'b0, div_quo[LANE_HI_X]};
	assign q_lo_y   = {1'b0, div_quo[LANE_LO_Y]};
	assign q_hi_y   = {1'b0, div_quo[LANE_HI_Y]};
	assign hic_x    = (q_hi_x > lim_c_m1) ? lim_c_m1 : q_hi_x;
	assign hic_y    = (q_hi_y > lim_r_m1) ? lim_r_m1 : q_hi_y;
	assign span_ok  = ok_x_q && ok_y_q && (lim_c != '0) && (lim_r != '0) &&
	                  (q_lo_x <= hic_x) && (q_lo_y <= hic_y);

	logic [COL_W-1:0] c0_q, c1_q;
	logic [ROW_W-1:0] r1_q, scan_row_q;
	logic             span_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.span_en) begin
			c0_q       <= COL_W'(q_lo_x);
			c1_q       <= COL_W'(hic_x);
			r1_q       <= ROW_W'(hic_y);
			scan_row_q <= ROW_W'(q_lo_y);
			span_ok_q  <= span_ok;
		end else if (cmd.scan_en) begin
			scan_row_q <= scan_row_q + 1'b1;
		end
	end

	// Clear pass row counter
	logic [ROW_W-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (cmd.clear_en) begin
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	// Row store
	logic                ram_wr_en, ram_rd_en;
	logic [ROW_W-1:0]    ram_wr_addr, ram_rd_addr;
	logic [MAX_COLS-1:0] ram_wr_data, ram_rd_data, row_mod;

	always_comb begin
		row_mod = ram_rd_data;
		row_mod[wr_col_q] = wr_bit_q;
	end

	assign ram_wr_en   = cmd.clear_en || (cmd.wb_en && wr_ok_q);
	assign ram_wr_addr = cmd.clear_en ? clr_row_q : wr_row_q;
	assign ram_wr_data = cmd.clear_en ? '0 : row_mod;
	assign ram_rd_en   = (cmd.accept && !in_op) || cmd.scan_en;
	assign ram_rd_addr = cmd.scan_en ? scan_row_q : ROW_W'(f_row);

	rvtc_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Scan check: one row a cycle against the column mask
	logic [MAX_COLS-1:0] col_mask;
	logic                rd_pend_s1;
	logic                hit_q;

	assign col_mask = ({MAX_COLS{1'b1}} << c0_q) &
	                  ({MAX_COLS{1'b1}} >> (COL_W'(MAX_COLS - 1) - c1_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.scan_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hit_q <= 1'b0;
		end else if (rd_pend_s1 && |(ram_rd_data & col_mask)) begin
			hit_q <= 1'b1;
		end
	end

	// Result register
	logic out_valid_q, out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q <= hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(OUT_DATA_W-1){1'b0}}, out_hit_q};

	assign status.in_is_query = in_op;
	assign status.clear_last  = (clr_row_q == ROW_W'(MAX_ROWS - 1));
	assign status.div_done    = div_done;
	assign status.span_ok     = span_ok_q;
	assign status.scan_last   = (scan_row_q == r1_q);
	assign status.out_free    = !out_valid_q || out_ready;

`ifndef ASSERT_OFF
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en && ram_wr_addr == ram_rd_addr))
		else $error("row store read and written at one address in one cycle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_check_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(cmd.scan_en))
		else $error("row check without a preceding row read");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rect_vs_tilemap_collision_top.sv =====
// Collision top level; depends on rvtc_pkg, rvtc_ctrl, rvtc_dp, rvtc_div and rvtc_ram.
// Write: the item is written back in ST_WB before the next item is taken; no result.
// Query: no new item is taken until the result is loaded. Steps in order: divide (16 steps,
// one quotient bit a cycle per lane, then done), span, one read per tile row scanned (none for an
// empty span), last-row check or empty-span exit, result load; a held result delays that load.
// Reset: async, active low, then a clearing pass over every row with s_axis_tready low.
`default_nettype none

module rect_vs_tilemap_collision_top
	import rvtc_pkg::*;
#(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// Configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	// Item input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tile_col[7:0], tile_row[15:8], solid_bit[16], rect_left[32:17], rect_top[48:33],
	// rect_width[60:49], rect_height[72:61], zero fill [79:73]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[0]: 0 writes a tile, 1 queries a rectangle
	input  wire logic [0:0]            s_axis_tuser,

	// Result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// hit[0], zero fill [7:1]
	output logic      [OUT_DATA_W-1:0] m_axis_tdata
);
	cmd_t    cmd;
	status_t status;

	// cfg_ready is tied high; the user must see that the block is only reconfigured while idle, it does not enforce this
	assign cfg_ready = 1'b1;

	// Handshake toward the source follows the sequencer; results sit in their own
	// register, so a new item may be taken while the previous result still waits
	assign s_axis_tready = cmd.in_ready;

	rvtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	rvtc_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_op     (s_axis_tuser[0]),
		.out_ready (m_axis_tready),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for rect_vs_tilemap_collision_top: tile writes and rectangle queries
// go in on the item stream, and a local tile map plus span arithmetic predicts every hit.
// Depends on rvtc_pkg and the RTL of the block; needs no files or arguments.

module tb_top
	import rvtc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_COLS       = 256;
	localparam int MAP_ROWS       = 256;
	localparam int SETTLE_CYCLES  = 16;      // long enough for a trailing write to finish
	localparam int TAIL_CYCLES    = 400;     // longer than a full-height query
	localparam int HOLDOFF_CYCLES = 400;
	localparam int CYCLE_LIMIT    = 3000000;

	// Register index that maps to nothing; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct {
		op_t                op;
		logic [7:0]         tile_col;
		logic [7:0]         tile_row;
		logic               solid;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic [11:0]        rect_width;
		logic [11:0]        rect_height;
	} tile_item_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [0:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Local copy of the block's state
	bit                    solid_store [MAP_ROWS][MAP_COLS];
	logic [CFG_DATA_W-1:0] tile_w_cfg = RST_TILE_W;
	logic [CFG_DATA_W-1:0] tile_h_cfg = RST_TILE_H;
	logic [CFG_DATA_W-1:0] map_w_cfg  = RST_MAP_W;
	logic [CFG_DATA_W-1:0] map_h_cfg  = RST_MAP_H;

	bit hit_expect_q [$];
	int fail_count          = 0;
	int cycle_count         = 0;
	int sink_holdoff_cycles = 0;
	bit src_idle_en         = 1'b1;
	bit sink_idle_en        = 1'b1;

	rect_vs_tilemap_collision_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Tiles along one axis that share pixels with [start, start + len) and lie below limit.
	function automatic bit axis_span(input int start, input int len, input int size,
	                                 input int limit, output int first, output int last);
		int stop;
		int div;
		stop = start + len;
		if (len == 0 || stop <= 0 || limit == 0)
			return 1'b0;
		div   = (size == 0) ? 1 : size;   // a zero tile size acts as one pixel
		first = (start > 0 ? start : 0) / div;
		last  = (stop - 1) / div;
		if (last > limit - 1)
			last = limit - 1;
		return first <= last;
	endfunction

	function automatic bit predict_hit(input tile_item_t it);
		int cols;
		int rows;
		int c0, c1, r0, r1;
		cols = (int'(map_w_cfg) < MAP_COLS) ? int'(map_w_cfg) : MAP_COLS;
		rows = (int'(map_h_cfg) < MAP_ROWS) ? int'(map_h_cfg) : MAP_ROWS;
		if (!axis_span(int'(it.rect_left), int'(it.rect_width), int'(tile_w_cfg), cols, c0, c1))
			return 1'b0;
		if (!axis_span(int'(it.rect_top), int'(it.rect_height), int'(tile_h_cfg), rows, r0, r1))
			return 1'b0;
		for (int r = r0; r <= r1; r++)
			for (int c = c0; c <= c1; c++)
				if (solid_store[r][c])
					return 1'b1;
		return 1'b0;
	endfunction

	function automatic tile_item_t make_item(input op_t op, input int col, input int row,
	                                         input int solid, input int left, input int top,
	                                         input int width, input int height);
		tile_item_t it;
		it.op          = op;
		it.tile_col    = 8'(col);
		it.tile_row    = 8'(row);
		it.solid       = 1'(solid);
		it.rect_left   = 16'(left);
		it.rect_top    = 16'(top);
		it.rect_width  = 12'(width);
		it.rect_height = 12'(height);
		return it;
	endfunction

	// Offer one item, hold it until the transaction, then update the prediction.
	// Leaves tvalid high so back-to-back items need no second assignment in one step.
	task automatic send_item(input tile_item_t it);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {7'd0, it.rect_height, it.rect_width, it.rect_top, it.rect_left,
		                  it.solid, it.tile_row, it.tile_col};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (it.op == OP_WRITE)
			solid_store[it.tile_row][it.tile_col] = it.solid;
		else
			hit_expect_q = {hit_expect_q, predict_hit(it)};
	endtask

	// Unused fields carry random junk: the block must ignore them
	task automatic send_write(input int col, input int row, input int solid);
		send_item(make_item(OP_WRITE, col, row, solid, $urandom_range(0, 65535),
		                    $urandom_range(0, 65535), $urandom_range(0, 4095),
		                    $urandom_range(0, 4095)));
	endtask

	task automatic send_query(input int left, input int top, input int width, input int height);
		send_item(make_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
		                    $urandom_range(0, 1), left, top, width, height));
	endtask

	// Drop valid, wait for every answer, then let any trailing write finish
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (hit_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TILE_W: tile_w_cfg = val;
			REG_TILE_H: tile_h_cfg = val;
			REG_MAP_W:  map_w_cfg  = val;
			REG_MAP_H:  map_h_cfg  = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int tw, input int th, input int mw, input int mh);
		wait_idle();
		write_reg(REG_TILE_W, 9'(tw));
		write_reg(REG_TILE_H, 9'(th));
		write_reg(REG_MAP_W, 9'(mw));
		write_reg(REG_MAP_H, 9'(mh));
	endtask

	// Tile writes mostly land in the top-left span x span corner so queries find them
	function automatic tile_item_t rand_write(input int span);
		tile_item_t it;
		it = make_item(OP_WRITE, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
		               int'($urandom_range(0, 9) < 7), $urandom_range(0, 65535),
		               $urandom_range(0, 65535), $urandom_range(0, 4095),
		               $urandom_range(0, 4095));
		if ($urandom_range(0, 3) == 0) begin
			it.tile_col = 8'($urandom_range(0, 255));
			it.tile_row = 8'($urandom_range(0, 255));
		end
		return it;
	endfunction

	// Queries are mostly sprite-sized around the populated corner, some start off-map
	// to the top-left; one in twenty is anything at all, up to the full map height.
	function automatic tile_item_t rand_query(input int span);
		tile_item_t it;
		int tw, th, wmax, hmax, pick;
		tw   = (tile_w_cfg == 0) ? 1 : int'(tile_w_cfg);
		th   = (tile_h_cfg == 0) ? 1 : int'(tile_h_cfg);
		wmax = (3 * tw > 4095) ? 4095 : 3 * tw;
		hmax = (3 * th > 4095) ? 4095 : 3 * th;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return make_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
			                 $urandom_range(0, 1), $urandom_range(0, 65535),
			                 $urandom_range(0, 65535), $urandom_range(0, 4095),
			                 $urandom_range(0, 4095));
		it = make_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
		               $urandom_range(0, 1),
		               int'($urandom_range(0, (span + 4) * tw)) - 3 * tw,
		               int'($urandom_range(0, (span + 4) * th)) - 3 * th,
		               $urandom_range(1, wmax), $urandom_range(1, hmax));
		if (pick == 1)
			it.rect_width = '0;
		else if (pick == 2)
			it.rect_height = '0;
		return it;
	endfunction

	task automatic run_random(input int count, input int span);
		for (int n = 0; n < count; n++)
			if ($urandom_range(0, 99) < 40)
				send_item(rand_write(span));
			else
				send_item(rand_query(span));
	endtask

	// Reset geometry: 16 x 16 pixel tiles, 256 x 256 map
	task automatic test_directed();
		send_query(0, 0, 4095, 4095);           // empty map, widest rectangle
		send_write(0, 0, 1);
		send_write(255, 255, 1);                // far corner of the store
		send_query(0, 0, 1, 1);
		send_query(0, 0, 0, 16);                // zero width never hits
		send_query(0, 0, 16, 0);                // zero height never hits
		send_query(-8, 0, 8, 16);               // ends exactly at pixel zero
		send_query(-8, -1, 9, 2);               // pokes one pixel into tile 0,0
		send_query(-32768, -32768, 4095, 4095); // entirely at negative pixels
		send_query(4080, 4080, 16, 16);         // last tile of the map
		send_query(4096, 4096, 100, 100);       // beyond the map
		send_query(32767, 32767, 4095, 4095);
		send_query(16, 0, 16, 16);              // neighbor tile is empty
		send_query(15, 0, 2, 1);                // touches the last pixel of tile 0,0
		send_write(0, 0, 0);                    // clear it again
		send_query(0, 0, 1, 1);
	endtask

	task automatic test_geometry_extremes();
		// Zero tile sizes act as one pixel; oversized map clamps to the store
		set_geometry(0, 0, 511, 511);
		send_write(3, 5, 1);
		send_write(255, 0, 1);
		send_query(3, 5, 1, 1);
		send_query(2, 5, 1, 1);
		send_query(255, 0, 1, 1);
		send_query(0, 0, 4095, 4095);
		// Tiles outside the map in use are kept and count once the map grows
		set_geometry(16, 16, 4, 4);
		send_write(10, 1, 1);
		send_query(0, 0, 4095, 4095);
		send_query(160, 16, 16, 16);
		wait_idle();
		write_reg(REG_MAP_W, 9'd16);
		send_query(160, 16, 16, 16);
		// An empty map never hits
		wait_idle();
		write_reg(REG_MAP_H, 9'd0);
		send_query(0, 0, 4095, 4095);
		// A write to an unmapped index changes nothing
		wait_idle();
		write_reg(REG_SPARE, 9'h1FF);
		write_reg(REG_MAP_H, 9'd4);
		send_query(160, 16, 16, 16);
		send_query(0, 0, 64, 64);
	endtask

	// Hold the result side off long enough for the block to back up into its input
	task automatic test_backpressure();
		set_geometry(16, 16, 256, 256);
		src_idle_en         = 1'b0;
		sink_holdoff_cycles = HOLDOFF_CYCLES;
		for (int n = 0; n < 40; n++)
			if (n % 5 == 0)
				send_item(rand_write(16));
			else
				send_item(rand_query(16));
		src_idle_en = 1'b1;
	endtask

	task automatic test_sender_pause();
		run_random(12, 16);
		wait_idle();
		run_random(12, 16);
	endtask

	task automatic test_random_phases();
		set_geometry(16, 16, 256, 256);
		run_random(280, 32);
		set_geometry(1, 1, 256, 256);
		run_random(280, 24);
		set_geometry(8, 4, 32, 20);
		run_random(260, 40);
		set_geometry(256, 256, 256, 256);
		run_random(240, 16);
		set_geometry(511, 3, 511, 1);
		run_random(240, 8);
		set_geometry(0, 0, 0, 7);
		run_random(60, 16);
		// Final stretch runs at full rate on both sides
		set_geometry(5, 9, 100, 200);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random(300, 32);
	endtask

	// Result side pacing: long hold-off on request, otherwise random stall bursts
	initial begin : sink_pacing
		forever begin
			@(posedge clk);
			if (sink_holdoff_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (sink_holdoff_cycles) @(posedge clk);
				sink_holdoff_cycles = 0;
				m_axis_tready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest predicted answer
	always @(posedge clk) begin : hit_checker
		bit exp_hit;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hit_expect_q.size() == 0) begin
				$error("unexpected result transaction: hit actual %0d", m_axis_tdata[0]);
				fail_count++;
			end else begin
				exp_hit = hit_expect_q.pop_front();
				if (m_axis_tdata[0] !== exp_hit) begin
					$error("hit mismatch: expected %0d actual %0d", exp_hit, m_axis_tdata[0]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rect_vs_tilemap_collision_top verification failed");
			$finish;
		end
	end

	initial begin : test_sequence
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_geometry_extremes();
		test_backpressure();
		test_sender_pause();
		test_random_phases();
		// Drain, then watch for stray results
		s_axis_tvalid <= 1'b0;
		while (hit_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("rect_vs_tilemap_collision_top verification clean");
		else
			$display("rect_vs_tilemap_collision_top verification failed");
		$finish;
	end

endmodule
